// File: rtl/core/cfp_pkg.sv
// Shared types and constants of the XOR checked frame parser.
// No dependencies; cfp_front, cfp_back and the top level import this package.
package cfp_pkg;

  localparam int MaxFrameLenDef = 256;
  localparam int MinFrameLen    = 5;
  localparam int CmdQDepth      = 2;
  localparam int ResQDepth      = 2;
  localparam int MemDepth       = 256;
  localparam logic [7:0] StartByteRst = 8'h02;

  // Request kinds, coded as the func field
  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_DONE    = 2'd1,
    ST_LEN_ERR = 2'd2,
    ST_XOR_ERR = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_LEN_HI = 7'b0000010,
    PH_LEN_LO = 7'b0000100,
    PH_CMD    = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_CHECK  = 7'b0100000,
    PH_READY  = 7'b1000000
  } phase_e;

  // Classified request from the front to the back
  typedef struct packed {
    op_e        op;
    logic [7:0] data;      // received byte or read index
    logic       is_start;  // data matches the start byte
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic       frame_ready;
    logic [7:0] command_code;
    logic [7:0] payload_length;
    logic [7:0] read_data;
  } res_t;

endpackage

// File: rtl/core/cfp_fifo.sv
// Small register queue with full and empty flags, used on both sides of the parser.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module cfp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

// File: rtl/core/cfp_front.sv
// Front of the parser: takes requests, classifies them and queues them.
// Depends on cfp_pkg and cfp_fifo.
module cfp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [1:0]    func_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [7:0]    read_index_i,
  input  logic [7:0]    start_byte_i,
  output logic          cmd_valid_o,
  output cfp_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import cfp_pkg::*;

  cmd_t cls;
  logic cmd_empty;

  always_comb begin
    cls.op       = op_e'(func_i);
    // a read carries its index, everything else the received byte
    cls.data     = (cls.op == OP_READ) ? read_index_i : rx_byte_i;
    cls.is_start = (rx_byte_i == start_byte_i);
  end

  cfp_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CmdQDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cls),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

// File: rtl/core/cfp_back.sv
// Back of the parser: frame state machine, data byte store and result queue.
// Depends on cfp_pkg and cfp_fifo.
module cfp_back #(
  parameter int MAX_FRAME_LEN = cfp_pkg::MaxFrameLenDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  cfp_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output cfp_pkg::res_t res_o,
  output logic          empty_o,
  input  logic          pop_i
);
  import cfp_pkg::*;

  localparam int BcW = $clog2(MAX_FRAME_LEN + 1);
  localparam logic [15:0] MaxLen = 16'(MAX_FRAME_LEN);
  localparam logic [15:0] MinLen = 16'(MinFrameLen);

  phase_e           phase_q, phase_d;
  logic [15:0]      flen_q, flen_d;
  logic [BcW-1:0]   bcnt_q, bcnt_d;
  logic [7:0]       wpos_q, wpos_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       xor_q, xor_d;

  logic [7:0]       mem_q [MemDepth];
  logic [7:0]       rdata_q;
  logic             mem_we, mem_re;

  logic             s2_valid_q;
  res_t             s2_res_q, s2_res_d;
  logic             s2_hit_q, s2_hit_d;
  logic             exec, s2_move, res_full;
  logic [15:0]      plen_diff;
  res_t             res_push;
  logic [7:0]       b;

  assign b         = cmd_i.data;
  assign s2_move   = s2_valid_q && !res_full;
  assign exec      = cmd_valid_i && (!s2_valid_q || s2_move);
  assign cmd_pop_o = exec;

  always_comb begin
    phase_d  = phase_q;
    flen_d   = flen_q;
    bcnt_d   = bcnt_q;
    wpos_d   = wpos_q;
    cmd_d    = cmd_q;
    xor_d    = xor_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    s2_hit_d = 1'b0;
    s2_res_d.status = ST_NONE;

    case (cmd_i.op)
      OP_RECV: begin
        case (phase_q)
          PH_LEN_HI: begin
            flen_d  = {b, 8'h00};
            xor_d   = b;
            bcnt_d  = BcW'(2);
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            flen_d = {flen_q[15:8], b};
            xor_d  = xor_q ^ b;
            bcnt_d = BcW'(3);
            if (flen_d < MinLen || flen_d > MaxLen) begin
              phase_d = PH_START;
              flen_d  = '0;
              bcnt_d  = '0;
              wpos_d  = '0;
              cmd_d   = '0;
              xor_d   = '0;
              s2_res_d.status = ST_LEN_ERR;
            end else begin
              phase_d = PH_CMD;
            end
          end
          PH_CMD: begin
            cmd_d   = b;
            xor_d   = xor_q ^ b;
            bcnt_d  = BcW'(4);
            wpos_d  = '0;
            phase_d = (flen_q == MinLen) ? PH_CHECK : PH_DATA;
          end
          PH_DATA: begin
            // keep at most 255 data bytes, still check all of them
            if (wpos_q != 8'hFF) begin
              mem_we = 1'b1;
              wpos_d = wpos_q + 8'd1;
            end
            xor_d  = xor_q ^ b;
            bcnt_d = bcnt_q + 1'b1;
            if ((16'(bcnt_q) + 16'd1) == (flen_q - 16'd1)) phase_d = PH_CHECK;
          end
          PH_CHECK: begin
            bcnt_d = bcnt_q + 1'b1;
            if (xor_q == b) begin
              phase_d = PH_READY;
              s2_res_d.status = ST_DONE;
            end else begin
              phase_d = PH_START;
              flen_d  = '0;
              bcnt_d  = '0;
              wpos_d  = '0;
              cmd_d   = '0;
              xor_d   = '0;
              s2_res_d.status = ST_XOR_ERR;
            end
          end
          PH_READY: begin
            // hold the verified frame, drop the byte
          end
          default: begin
            phase_d = PH_START;
            if (cmd_i.is_start) begin
              phase_d = PH_LEN_HI;
              bcnt_d  = BcW'(1);
            end
          end
        endcase
      end
      OP_CLEAR: begin
        phase_d = PH_START;
        flen_d  = '0;
        bcnt_d  = '0;
        wpos_d  = '0;
        cmd_d   = '0;
        xor_d   = '0;
      end
      OP_READ: begin
        mem_re   = 1'b1;
        s2_hit_d = (b < wpos_q);
      end
      default: begin
      end
    endcase

    plen_diff = flen_d - MinLen;
    s2_res_d.frame_ready  = (phase_d == PH_READY);
    s2_res_d.command_code = cmd_d;
    if (flen_d <= MinLen)          s2_res_d.payload_length = 8'd0;
    else if (plen_diff > 16'd255)  s2_res_d.payload_length = 8'hFF;
    else                           s2_res_d.payload_length = plen_diff[7:0];
    s2_res_d.read_data = 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      flen_q     <= '0;
      bcnt_q     <= '0;
      wpos_q     <= '0;
      cmd_q      <= '0;
      xor_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      if (exec) begin
        phase_q <= phase_d;
        flen_q  <= flen_d;
        bcnt_q  <= bcnt_d;
        wpos_q  <= wpos_d;
        cmd_q   <= cmd_d;
        xor_q   <= xor_d;
      end
      if (exec)         s2_valid_q <= 1'b1;
      else if (s2_move) s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      s2_res_q <= s2_res_d;
      s2_hit_q <= s2_hit_d;
    end
  end

  // Data store: one write or one read per request, read data registered
  always_ff @(posedge clk_i) begin
    if (exec && mem_we) mem_q[wpos_q] <= b;
    if (exec && mem_re) rdata_q <= mem_q[b];
  end

  always_comb begin
    res_push = s2_res_q;
    res_push.read_data = s2_hit_q ? rdata_q : 8'd0;
  end

  cfp_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (ResQDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .data_i  (res_push),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_o),
    .empty_o (empty_o)
  );

endmodule

// File: rtl/core/xor_checked_frame_parser.sv
// Top level of the XOR checked frame parser: APB register and front/back parts.
// Depends on cfp_pkg, cfp_front and cfp_back.
//
//   channel   direction  handshake              payload
//   request   in         push / full            func_i, rx_byte_i, read_index_i
//   result    out        empty / pop            status_o, frame_ready_o, command_code_o,
//                                               payload_length_o, read_data_o
//   config    in         psel/penable/pwrite    paddr, pwdata, prdata (start byte at 0)
//
// One request per cycle sustained while the result side keeps up; a result passes from
// the request queue through the frame state update, together with the data store read
// register, into the result queue and can be popped from the cycle after it enters.
// Reset clears the queues and the frame state and sets the start byte to 0x02;
// the data store is not cleared. A stalled result side fills the two-entry result
// queue, the one-entry stage register and the two-entry request queue: full rises at five held requests.
module xor_checked_frame_parser #(
  parameter int MAX_FRAME_LEN = cfp_pkg::MaxFrameLenDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  read_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic        frame_ready_o,
  output logic [7:0]  command_code_o,
  output logic [7:0]  payload_length_o,
  output logic [7:0]  read_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfp_pkg::*;

  logic [7:0] start_byte_q;
  logic       cmd_valid, cmd_pop;
  cmd_t       cmd;
  res_t       res;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, start_byte_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= StartByteRst;
    end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
      start_byte_q <= pwdata[7:0];
    end
  end

  cfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .func_i       (func_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .start_byte_i (start_byte_q),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  cfp_back #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .empty_o     (empty),
    .pop_i       (pop)
  );

  assign status_o         = res.status;
  assign frame_ready_o    = res.frame_ready;
  assign command_code_o   = res.command_code;
  assign payload_length_o = res.payload_length;
  assign read_data_o      = res.read_data;

endmodule
